>>> sv/mbr_pkg.sv
// Shared constants for the MSB-first Exp-Golomb bit reader.
package mbr_pkg;
  localparam int STORE_BYTES    = 4096;
  localparam int ADDR_W         = $clog2(STORE_BYTES);
  localparam int CNT_W          = ADDR_W + 1;
  localparam int POS_W          = CNT_W + 3;
  localparam int MAX_FIXED_BITS = 32;

  localparam logic [3:0] REQ_APPEND = 4'd0;
  localparam logic [3:0] REQ_CLEAR  = 4'd1;
  localparam logic [3:0] REQ_REWIND = 4'd2;
  localparam logic [3:0] REQ_READ   = 4'd3;
  localparam logic [3:0] REQ_PEEK   = 4'd4;
  localparam logic [3:0] REQ_SIGNED = 4'd5;
  localparam logic [3:0] REQ_UE     = 4'd6;
  localparam logic [3:0] REQ_SE     = 4'd7;
  localparam logic [3:0] REQ_RBSP   = 4'd8;
  localparam logic [3:0] REQ_ALIGN  = 4'd9;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NODATA   = 3'd1;
  localparam logic [2:0] ST_BADTRAIL = 3'd2;
  localparam logic [2:0] ST_BADLEN   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_LONG     = 3'd5;
endpackage

>>> sv/msb_first_bit_reader_exp_golomb.sv
// Top level of the MSB-first bit reader with Exp-Golomb decoding.
// Requests arrive on the in_ stream: in_tuser carries the request kind, in_tdata
// the byte to append and the bit count. Each accepted word yields exactly one
// result word on the out_ stream: value, bits used, bits remaining and status.
// Payload bytes live in a synchronous byte RAM; reads walk the bit cursor one
// bit a cycle, with a fetch from the RAM each time a new byte is entered.
// Append, clear, rewind, align and requests refused at once pass from accept
// through the execute state to the result state; bit reads also fetch bytes
// and examine bits, up to 63 of them for an Exp-Golomb code.
// One request is in flight at once and in_tready is high only while the
// sequencer is idle, so a new word is taken only after the result of the last
// one has been written to the output register.
// The result sits in an output register; while the receiver stalls the next
// request is still accepted and worked on, and its result waits until the
// register is free. Reset empties the store and zeroes the bit position; the
// byte RAM itself is not cleared, as only bytes already written are read.
module msb_first_bit_reader_exp_golomb
  import mbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [13:8] bit_count, [15:14] zero
  input  logic [3:0]  in_tuser,   // [3:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [31:0] value, [38:32] bits_used,
                                  // [54:39] bits_remaining, [57:55] status, rest zero
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_BIT   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam logic [2:0] M_FIX  = 3'd0;
  localparam logic [2:0] M_PRE  = 3'd1;
  localparam logic [2:0] M_SUF  = 3'd2;
  localparam logic [2:0] M_STOP = 3'd3;
  localparam logic [2:0] M_ALZ  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [2:0]       mode_r, mode_nxt;
  logic [3:0]       req_r;
  logic [7:0]       dbyte_r;
  logic [5:0]       n_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] p_r, p_nxt;
  logic [POS_W-1:0] rem_r, rem_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [5:0]       zeros_r, zeros_nxt;
  logic [2:0]       a_r, a_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [2:0]       status_r, status_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_value_r, out_value_nxt;
  logic [6:0]       out_used_r, out_used_nxt;
  logic [15:0]      out_rem_r, out_rem_nxt;
  logic [2:0]       out_status_r, out_status_nxt;

  logic             wr_en, rd_en;
  logic [7:0]       ram_q;
  logic [POS_W-1:0] left;
  logic             b;
  logic [31:0]      code, val;
  logic [POS_W-1:0] p_commit;
  logic             commit;
  logic [2:0]       align_a;

  mbr_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (dbyte_r),
    .rd_en   (rd_en),
    .rd_addr (p_r[ADDR_W+2:3]),
    .rd_data (ram_q)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r, out_rem_r, out_used_r, out_value_r};

  assign left    = {count_r, 3'b000} - pos_r;
  assign b       = (p_r[POS_W-1:3] < count_r) ? ram_q[3'd7 - p_r[2:0]] : 1'b0;
  assign code    = ((32'd1 << zeros_r[4:0]) - 32'd1) + acc_r;
  assign align_a = 3'd0 - pos_r[2:0];
  assign commit  = (status_r == ST_OK) && (req_r != REQ_PEEK);
  assign p_commit = commit ? p_r : pos_r;

  always_comb begin
    case (req_r)
      REQ_READ, REQ_PEEK: val = acc_r;
      REQ_SIGNED: begin
        if (n_r < 6'd32 && acc_r[n_r[4:0] - 5'd1]) begin
          val = acc_r | (32'hffff_ffff << n_r[4:0]);
        end else begin
          val = acc_r;
        end
      end
      REQ_UE: val = code;
      REQ_SE: val = code[0] ? (code >> 1) + 32'd1 : 32'd0 - (code >> 1);
      default: val = 32'd0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    p_nxt      = p_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    zeros_nxt  = zeros_r;
    a_nxt      = a_r;
    acc_nxt    = acc_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;

    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_used_nxt   = out_used_r;
    out_rem_nxt    = out_rem_r;
    out_status_nxt = out_status_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = ST_OK;
        p_nxt      = pos_r;
        rem_nxt    = left;
        acc_nxt    = 32'd0;
        zeros_nxt  = 6'd0;
        cnt_nxt    = n_r;
        state_nxt  = S_FIN;
        case (req_r)
          REQ_APPEND: begin
            if (count_r >= CNT_W'(STORE_BYTES)) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          REQ_CLEAR: begin
            count_nxt = '0;
            pos_nxt   = '0;
            p_nxt     = '0;
          end
          REQ_REWIND: begin
            pos_nxt = '0;
            p_nxt   = '0;
          end
          REQ_READ, REQ_PEEK, REQ_SIGNED: begin
            if (n_r == 6'd0 || n_r > 6'(MAX_FIXED_BITS)) begin
              status_nxt = ST_BADLEN;
            end else if (req_r != REQ_PEEK && POS_W'(n_r) > left) begin
              status_nxt = ST_NODATA;
            end else begin
              mode_nxt  = M_FIX;
              state_nxt = S_FETCH;
            end
          end
          REQ_UE, REQ_SE: begin
            mode_nxt  = M_PRE;
            state_nxt = S_FETCH;
          end
          REQ_RBSP: begin
            if (left == '0) begin
              status_nxt = ST_NODATA;
            end else begin
              a_nxt     = ~pos_r[2:0];
              mode_nxt  = M_STOP;
              state_nxt = S_FETCH;
            end
          end
          REQ_ALIGN: begin
            if (POS_W'(align_a) > left) begin
              p_nxt = pos_r + left;
            end else begin
              p_nxt = pos_r + POS_W'(align_a);
            end
          end
          default: ;
        endcase
      end
      S_FETCH: begin
        rd_en     = 1'b1;
        state_nxt = S_BIT;
      end
      S_BIT: begin
        state_nxt = ((p_r[2:0] == 3'd7) ? S_FETCH : S_BIT);
        case (mode_r)
          M_FIX: begin
            acc_nxt = {acc_r[30:0], b};
            p_nxt   = p_r + 1'b1;
            cnt_nxt = cnt_r - 1'b1;
            if (cnt_r == 6'd1) begin
              state_nxt = S_FIN;
            end
          end
          M_PRE: begin
            if (rem_r == '0) begin
              status_nxt = ST_NODATA;
              state_nxt  = S_FIN;
            end else if (b) begin
              p_nxt   = p_r + 1'b1;
              rem_nxt = rem_r - 1'b1;
              if (zeros_r == 6'd0) begin
                state_nxt = S_FIN;
              end else if (rem_r - 1'b1 < POS_W'(zeros_r)) begin
                status_nxt = ST_NODATA;
                state_nxt  = S_FIN;
              end else begin
                mode_nxt = M_SUF;
                cnt_nxt  = zeros_r;
              end
            end else begin
              p_nxt     = p_r + 1'b1;
              rem_nxt   = rem_r - 1'b1;
              zeros_nxt = zeros_r + 1'b1;
              if (zeros_r == 6'd31) begin
                status_nxt = ST_LONG;
                state_nxt  = S_FIN;
              end
            end
          end
          M_SUF: begin
            acc_nxt = {acc_r[30:0], b};
            p_nxt   = p_r + 1'b1;
            cnt_nxt = cnt_r - 1'b1;
            if (cnt_r == 6'd1) begin
              state_nxt = S_FIN;
            end
          end
          M_STOP: begin
            if (!b) begin
              status_nxt = ST_BADTRAIL;
              state_nxt  = S_FIN;
            end else if (POS_W'(a_r) + 1'b1 > rem_r) begin
              status_nxt = ST_NODATA;
              state_nxt  = S_FIN;
            end else begin
              p_nxt = p_r + 1'b1;
              if (a_r == 3'd0) begin
                state_nxt = S_FIN;
              end else begin
                mode_nxt = M_ALZ;
                cnt_nxt  = {3'd0, a_r};
              end
            end
          end
          M_ALZ: begin
            if (b) begin
              status_nxt = ST_BADTRAIL;
              state_nxt  = S_FIN;
            end else begin
              p_nxt   = p_r + 1'b1;
              cnt_nxt = cnt_r - 1'b1;
              if (cnt_r == 6'd1) begin
                state_nxt = S_FIN;
              end
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_FIN: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = (status_r == ST_OK) ? val : 32'd0;
          out_used_nxt   = commit ? 7'(p_r - pos_r) : 7'd0;
          out_rem_nxt    = 16'({count_r, 3'b000} - p_commit);
          out_status_nxt = status_r;
          pos_nxt        = p_commit;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      req_r   <= in_tuser;
      dbyte_r <= in_tdata[7:0];
      n_r     <= in_tdata[13:8];
    end
    mode_r       <= mode_nxt;
    p_r          <= p_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    zeros_r      <= zeros_nxt;
    a_r          <= a_nxt;
    acc_r        <= acc_nxt;
    status_r     <= status_nxt;
    out_value_r  <= out_value_nxt;
    out_used_r   <= out_used_nxt;
    out_rem_r    <= out_rem_nxt;
    out_status_r <= out_status_nxt;
  end
endmodule

>>> sv/mbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
